[rtl/heightmap_vertex_normal_stream_assert.svh]
// ----------------------------------------------------------------------------
// Heightmap vertex normal stream: assertion macros
// Concurrent checks with a clock and a synchronous reset; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_NORMAL_STREAM_ASSERT_SVH
`define HEIGHTMAP_VERTEX_NORMAL_STREAM_ASSERT_SVH
`ifndef SYNTHESIS
// property holds at every edge outside reset
`define HVNS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hvns: property failed");
// condition implies a property in the next cycle
`define HVNS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("hvns: next-cycle property failed");
`else
`define HVNS_ASSERT(lbl, clk, rst, prop)
`define HVNS_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

[rtl/hvns_pkg.sv]
// ----------------------------------------------------------------------------
// hvns_pkg
// Types and constants shared by the heightmap vertex normal stream modules.
// ----------------------------------------------------------------------------
package hvns_pkg;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERT_SCALE   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPACING_X    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPACING_Z    = 3'd4;
   localparam logic [15:0] CSR_RESET_VALUE = 16'd256;

   // sequencer step counts
   localparam int unsigned ROOT_STEPS = 32;
   localparam int unsigned DIV_STEPS  = 16;
   localparam int unsigned CNT_BITS   = 5;

   // arithmetic constants
   localparam logic [15:0] NORM_ONE       = 16'd16384;  // 1.0 in Q1.14
   localparam logic [9:0]  Y_TERM         = 10'd512;    // 2.0 in Q.8
   localparam logic [63:0] ROOT_FIRST_BIT = 64'h4000_0000_0000_0000;

   typedef struct packed {
      logic        operation;
      logic [15:0] sample_height;
   } req_type;

   typedef struct packed {
      logic        [9:0]  column;
      logic        [15:0] grid_row;
      logic        [25:0] pos_x;
      logic        [31:0] pos_y;
      logic        [31:0] pos_z;
      logic        [15:0] tex_u;
      logic        [15:0] tex_v;
      logic signed [15:0] normal_x;
      logic        [14:0] normal_y;
      logic signed [15:0] normal_z;
      logic               last_vertex;
   } rsp_type;

   // one line store word: row before last, and last row
   typedef struct packed {
      logic [31:0] older;
      logic [31:0] prev;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CUR, ST_RDC, ST_RDL, ST_RDR, ST_CAPR, ST_PREP,
      ST_SQA, ST_SQB, ST_SQC, ST_SQD, ST_ROOT_LD, ST_ROOT,
      ST_DIV_LD, ST_DIV_RUN, ST_DIV_ST, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_CUR, MUL_SQA, MUL_SQB, MUL_SQC, MUL_PX, MUL_PZ
   } mul_sel_type;

   typedef enum logic [2:0] {
      DIV_NX, DIV_NY, DIV_NZ, DIV_TU, DIV_TV
   } div_sel_type;

   typedef struct packed {
      logic        in_load;
      logic        rd_en;
      logic        cap_c;
      logic        cap_l;
      logic        cap_r;
      logic        mem_wr;
      logic        prep;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        root_load;
      logic        root_step;
      logic        div_load;
      logic        div_step;
      logic        div_store;
      div_sel_type div_sel;
      logic        out_load;
      logic        drain;
      logic        low_row;
      logic        edge_l;
      logic        edge_r;
      logic        last;
      logic [15:0] vrow;
   } cmd_type;

endpackage

[rtl/hvns_ctrl.sv]
// ----------------------------------------------------------------------------
// hvns_ctrl
// Sequencer: grid counters, handshakes and the command stream for the datapath.
// ----------------------------------------------------------------------------
`include "heightmap_vertex_normal_stream_assert.svh"

module hvns_ctrl #(
   parameter int AW = 10,
   parameter int WW = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_op,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              cfg_clear,
   input  logic [WW-1:0]     eff_w,
   input  logic [15:0]       eff_h,
   output hvns_pkg::cmd_type cmd,
   output logic [AW-1:0]     rd_addr,
   output logic [AW-1:0]     vcol
);

   hvns_pkg::state_type   state_ff, state_in;
   hvns_pkg::div_sel_type dsel_ff, dsel_in;
   logic [AW-1:0] col_ff, col_in, drn_ff, drn_in, vcol_ff, vcol_in;
   logic [15:0]   row_ff, row_in, vrow_ff, vrow_in;
   logic          drain_ff, drain_in, emit_ff, emit_in, low_ff, low_in;
   logic          el_ff, el_in, er_ff, er_in, last_ff, last_in;
   logic [hvns_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0] col_w, col_next, drn_w, drn_next;

   assign col_w    = WW'(col_ff);
   assign col_next = col_w + WW'(1);
   assign drn_w    = WW'(drn_ff);
   assign drn_next = drn_w + WW'(1);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      drn_in       = drn_ff;
      vcol_in      = vcol_ff;
      vrow_in      = vrow_ff;
      drain_in     = drain_ff;
      emit_in      = emit_ff;
      low_in       = low_ff;
      el_in        = el_ff;
      er_in        = er_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      dsel_in      = dsel_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      rd_addr      = vcol_ff;
      cmd          = '0;
      cmd.mul_sel  = hvns_pkg::MUL_NONE;
      cmd.div_sel  = dsel_ff;
      cmd.drain    = drain_ff;
      cmd.low_row  = low_ff;
      cmd.edge_l   = el_ff;
      cmd.edge_r   = er_ff;
      cmd.last     = last_ff;
      cmd.vrow     = vrow_ff;
      case (state_ff)
         hvns_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.in_load = 1'b1;
               if (!req_op) begin
                  // push: emits the vertex one row above
                  if (row_ff < eff_h && col_w < eff_w) begin
                     vcol_in  = col_ff;
                     vrow_in  = row_ff - 16'd1;
                     drain_in = 1'b0;
                     emit_in  = (row_ff != 16'd0);
                     low_in   = (row_ff < 16'd2);
                     el_in    = (col_ff == '0);
                     er_in    = (col_next >= eff_w);
                     last_in  = 1'b0;
                     if (col_next >= eff_w) begin
                        col_in = '0;
                        row_in = row_ff + 16'd1;
                     end else begin
                        col_in = AW'(col_next);
                     end
                     state_in = hvns_pkg::ST_CUR;
                  end
               end else if (row_ff >= eff_h && drn_w < eff_w) begin
                  // drain: one vertex of the last row
                  vcol_in  = drn_ff;
                  vrow_in  = eff_h - 16'd1;
                  drain_in = 1'b1;
                  emit_in  = 1'b1;
                  low_in   = (eff_h < 16'd2);
                  el_in    = (drn_ff == '0);
                  er_in    = (drn_next >= eff_w);
                  last_in  = (drn_next >= eff_w);
                  if (drn_next >= eff_w) begin
                     col_in = '0;
                     row_in = '0;
                     drn_in = '0;
                  end else begin
                     drn_in = AW'(drn_next);
                  end
                  state_in = hvns_pkg::ST_RDC;
               end
            end
         end
         hvns_pkg::ST_CUR: begin
            cmd.rd_en   = 1'b1;
            cmd.mul_sel = hvns_pkg::MUL_CUR;
            state_in    = hvns_pkg::ST_RDL;
         end
         hvns_pkg::ST_RDC: begin
            cmd.rd_en = 1'b1;
            state_in  = hvns_pkg::ST_RDL;
         end
         hvns_pkg::ST_RDL: begin
            cmd.cap_c  = 1'b1;
            cmd.mem_wr = ~drain_ff;
            cmd.rd_en  = 1'b1;
            rd_addr    = vcol_ff - AW'(1);
            state_in   = emit_ff ? hvns_pkg::ST_RDR : hvns_pkg::ST_IDLE;
         end
         hvns_pkg::ST_RDR: begin
            cmd.cap_l = 1'b1;
            cmd.rd_en = 1'b1;
            rd_addr   = vcol_ff + AW'(1);
            state_in  = hvns_pkg::ST_CAPR;
         end
         hvns_pkg::ST_CAPR: begin
            cmd.cap_r = 1'b1;
            state_in  = hvns_pkg::ST_PREP;
         end
         hvns_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = hvns_pkg::ST_SQA;
         end
         hvns_pkg::ST_SQA: begin
            cmd.mul_sel = hvns_pkg::MUL_SQA;
            state_in    = hvns_pkg::ST_SQB;
         end
         hvns_pkg::ST_SQB: begin
            cmd.mul_sel  = hvns_pkg::MUL_SQB;
            cmd.acc_load = 1'b1;
            state_in     = hvns_pkg::ST_SQC;
         end
         hvns_pkg::ST_SQC: begin
            cmd.mul_sel = hvns_pkg::MUL_SQC;
            cmd.acc_add = 1'b1;
            state_in    = hvns_pkg::ST_SQD;
         end
         hvns_pkg::ST_SQD: begin
            cmd.mul_sel = hvns_pkg::MUL_PX;
            cmd.acc_add = 1'b1;
            state_in    = hvns_pkg::ST_ROOT_LD;
         end
         hvns_pkg::ST_ROOT_LD: begin
            cmd.mul_sel   = hvns_pkg::MUL_PZ;
            cmd.root_load = 1'b1;
            cnt_in        = '0;
            state_in      = hvns_pkg::ST_ROOT;
         end
         hvns_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == hvns_pkg::CNT_BITS'(hvns_pkg::ROOT_STEPS - 1)) begin
               dsel_in  = hvns_pkg::DIV_NX;
               state_in = hvns_pkg::ST_DIV_LD;
            end
         end
         hvns_pkg::ST_DIV_LD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = hvns_pkg::ST_DIV_RUN;
         end
         hvns_pkg::ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == hvns_pkg::CNT_BITS'(hvns_pkg::DIV_STEPS - 1)) begin
               state_in = hvns_pkg::ST_DIV_ST;
            end
         end
         hvns_pkg::ST_DIV_ST: begin
            cmd.div_store = 1'b1;
            state_in      = hvns_pkg::ST_DIV_LD;
            case (dsel_ff)
               hvns_pkg::DIV_NX: dsel_in = hvns_pkg::DIV_NY;
               hvns_pkg::DIV_NY: dsel_in = hvns_pkg::DIV_NZ;
               hvns_pkg::DIV_NZ: dsel_in = hvns_pkg::DIV_TU;
               hvns_pkg::DIV_TU: dsel_in = hvns_pkg::DIV_TV;
               default:          state_in = hvns_pkg::ST_OUT;
            endcase
         end
         hvns_pkg::ST_OUT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = hvns_pkg::ST_IDLE;
            end
         end
         default: state_in = hvns_pkg::ST_IDLE;
      endcase
      // register write restarts the stream
      if (cfg_clear) begin
         col_in = '0;
         row_in = '0;
         drn_in = '0;
      end
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hvns_pkg::ST_IDLE;
         dsel_ff      <= hvns_pkg::DIV_NX;
         col_ff       <= '0;
         row_ff       <= '0;
         drn_ff       <= '0;
         vcol_ff      <= '0;
         vrow_ff      <= '0;
         drain_ff     <= 1'b0;
         emit_ff      <= 1'b0;
         low_ff       <= 1'b0;
         el_ff        <= 1'b0;
         er_ff        <= 1'b0;
         last_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dsel_ff      <= dsel_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         drn_ff       <= drn_in;
         vcol_ff      <= vcol_in;
         vrow_ff      <= vrow_in;
         drain_ff     <= drain_in;
         emit_ff      <= emit_in;
         low_ff       <= low_in;
         el_ff        <= el_in;
         er_ff        <= er_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign vcol      = vcol_ff;

   `HVNS_ASSERT(a_col_in_grid, clock, reset, col_w < eff_w)
   `HVNS_ASSERT(a_drain_in_grid, clock, reset, drn_w < eff_w)
   `HVNS_ASSERT(a_no_result_lost, clock, reset, !cmd.out_load || !rsp_valid_ff || rsp_ready)
   `HVNS_ASSERT_NEXT(a_root_runs_full, clock, reset, state_ff == hvns_pkg::ST_ROOT && cnt_ff != hvns_pkg::CNT_BITS'(hvns_pkg::ROOT_STEPS - 1), state_ff == hvns_pkg::ST_ROOT)

endmodule

[rtl/hvns_dp.sv]
// ----------------------------------------------------------------------------
// hvns_dp
// Datapath: line store, shared multiplier, square root and divider units.
// ----------------------------------------------------------------------------
module hvns_dp #(
   parameter int MAX_WIDTH = 1024,
   parameter int AW        = 10,
   parameter int WW        = 11
) (
   input  logic              clock,
   input  hvns_pkg::req_type req_data,
   input  hvns_pkg::cmd_type cmd,
   input  logic [AW-1:0]     rd_addr,
   input  logic [AW-1:0]     vcol,
   input  logic [WW-1:0]     eff_w,
   input  logic [15:0]       eff_h,
   input  logic [15:0]       vert_scale,
   input  logic [15:0]       spacing_x,
   input  logic [15:0]       spacing_z,
   output hvns_pkg::rsp_type rsp_data
);

   // line store: both rows at one address
   hvns_pkg::entry_type mem [MAX_WIDTH];
   hvns_pkg::entry_type rd_ff;

   logic [15:0] sample_ff;
   logic [31:0] cur_ff, c_ff, l_ff, r_ff, dn_ff;
   logic [30:0] a_ff, cz_ff, a_in, cz_in;
   logic [9:0]  b_ff, b_in;
   logic        nxneg_ff, nzneg_ff, nxneg_in, nzneg_in;
   logic [31:0] l_sel, r_sel, dn_sel, up_sel, ax, az;
   logic        shift_down;
   logic [31:0] op_a, op_b;
   logic [63:0] prod, p_ff, acc_ff;
   logic [25:0] posx_ff;
   logic [31:0] posz_ff;
   logic [63:0] rv_ff, res_ff, bit_ff, root_try;
   logic        root_ge;
   logic [31:0] len, den;
   logic [47:0] num, rem_ff, dsh_ff;
   logic        div_ge;
   logic [15:0] q_ff, qc;
   logic [15:0] nx_ff, nz_ff, tu_ff, tv_ff;
   logic [14:0] ny_ff;
   hvns_pkg::rsp_type out_ff;

   // store access: read registered, write of old last row and new row
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[vcol] <= '{older: rd_ff.prev, prev: cur_ff};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // neighbour capture
   always_ff @(posedge clock) begin
      if (cmd.in_load) begin
         sample_ff <= req_data.sample_height;
      end
      if (cmd.cap_c) begin
         c_ff  <= rd_ff.prev;
         dn_ff <= rd_ff.older;
      end
      if (cmd.cap_l) begin
         l_ff <= cmd.drain ? rd_ff.prev : rd_ff.older;
      end
      if (cmd.cap_r) begin
         r_ff <= rd_ff.prev;
      end
   end

   // differences with edge clamping, scaled below 2^31
   always_comb begin
      l_sel      = cmd.edge_l  ? c_ff : l_ff;
      r_sel      = cmd.edge_r  ? c_ff : r_ff;
      dn_sel     = cmd.low_row ? c_ff : dn_ff;
      up_sel     = cmd.drain   ? c_ff : cur_ff;
      nxneg_in   = r_sel > l_sel;
      nzneg_in   = up_sel > dn_sel;
      ax         = nxneg_in ? r_sel - l_sel : l_sel - r_sel;
      az         = nzneg_in ? up_sel - dn_sel : dn_sel - up_sel;
      shift_down = ax[31] | az[31];
      a_in       = shift_down ? ax[31:1] : ax[30:0];
      cz_in      = shift_down ? az[31:1] : az[30:0];
      b_in       = shift_down ? (hvns_pkg::Y_TERM >> 1) : hvns_pkg::Y_TERM;
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         cz_ff    <= cz_in;
         nxneg_ff <= nxneg_in;
         nzneg_ff <= nzneg_in;
      end
   end

   // shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         hvns_pkg::MUL_CUR: begin
            op_a = 32'(sample_ff);
            op_b = 32'(vert_scale);
         end
         hvns_pkg::MUL_SQA: begin
            op_a = 32'(a_ff);
            op_b = 32'(a_ff);
         end
         hvns_pkg::MUL_SQB: begin
            op_a = 32'(b_ff);
            op_b = 32'(b_ff);
         end
         hvns_pkg::MUL_SQC: begin
            op_a = 32'(cz_ff);
            op_b = 32'(cz_ff);
         end
         hvns_pkg::MUL_PX: begin
            op_a = 32'(vcol);
            op_b = 32'(spacing_x);
         end
         hvns_pkg::MUL_PZ: begin
            op_a = 32'(cmd.vrow);
            op_b = 32'(spacing_z);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod = op_a * op_b;

   always_ff @(posedge clock) begin
      case (cmd.mul_sel)
         hvns_pkg::MUL_CUR: cur_ff  <= prod[31:0];
         hvns_pkg::MUL_SQA: p_ff    <= prod;
         hvns_pkg::MUL_SQB: p_ff    <= prod;
         hvns_pkg::MUL_SQC: p_ff    <= prod;
         hvns_pkg::MUL_PX:  posx_ff <= prod[25:0];
         hvns_pkg::MUL_PZ:  posz_ff <= prod[31:0];
         default: ;
      endcase
      // sum of squares
      if (cmd.acc_load) begin
         acc_ff <= p_ff;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + p_ff;
      end
   end

   // integer square root, two radicand bits a step
   assign root_try = res_ff + bit_ff;
   assign root_ge  = rv_ff >= root_try;
   assign len      = res_ff[31:0];

   always_ff @(posedge clock) begin
      if (cmd.root_load) begin
         rv_ff  <= acc_ff;
         res_ff <= '0;
         bit_ff <= hvns_pkg::ROOT_FIRST_BIT;
      end else if (cmd.root_step) begin
         if (root_ge) begin
            rv_ff  <= rv_ff - root_try;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // divider operands: rounded normal parts and texture coordinates
   always_comb begin
      case (cmd.div_sel)
         hvns_pkg::DIV_NX: begin
            num = (48'(a_ff) << 14) + 48'(len >> 1);
            den = len;
         end
         hvns_pkg::DIV_NY: begin
            num = (48'(b_ff) << 14) + 48'(len >> 1);
            den = len;
         end
         hvns_pkg::DIV_NZ: begin
            num = (48'(cz_ff) << 14) + 48'(len >> 1);
            den = len;
         end
         hvns_pkg::DIV_TU: begin
            num = 48'(vcol) << 16;
            den = 32'(eff_w);
         end
         hvns_pkg::DIV_TV: begin
            num = 48'(cmd.vrow) << 16;
            den = 32'(eff_h);
         end
         default: begin
            num = '0;
            den = 32'd1;
         end
      endcase
   end

   // restoring divider, one quotient bit a step
   assign div_ge = rem_ff >= dsh_ff;
   assign qc     = (q_ff > hvns_pkg::NORM_ONE) ? hvns_pkg::NORM_ONE : q_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= num;
         dsh_ff <= 48'(den) << 15;
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         q_ff   <= {q_ff[14:0], div_ge};
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.div_store) begin
         case (cmd.div_sel)
            hvns_pkg::DIV_NX: nx_ff <= nxneg_ff ? 16'd0 - qc : qc;
            hvns_pkg::DIV_NY: ny_ff <= qc[14:0];
            hvns_pkg::DIV_NZ: nz_ff <= nzneg_ff ? 16'd0 - qc : qc;
            hvns_pkg::DIV_TU: tu_ff <= q_ff;
            hvns_pkg::DIV_TV: tv_ff <= q_ff;
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.column      <= 10'(vcol);
         out_ff.grid_row    <= cmd.vrow;
         out_ff.pos_x       <= posx_ff;
         out_ff.pos_y       <= c_ff;
         out_ff.pos_z       <= posz_ff;
         out_ff.tex_u       <= tu_ff;
         out_ff.tex_v       <= tv_ff;
         out_ff.normal_x    <= $signed(nx_ff);
         out_ff.normal_y    <= ny_ff;
         out_ff.normal_z    <= $signed(nz_ff);
         out_ff.last_vertex <= cmd.last;
      end
   end

   assign rsp_data = out_ff;

endmodule

[rtl/heightmap_vertex_normal_stream.sv]
// An emitting item runs through the neighbour reads, the sum of squares, the 32-step
// square root and five 16-step divisions on the shared divider before its result is
// valid; no new item is taken until then. A push on row zero only updates the store.
// A waiting result does not stop the next item being taken, only its output load.
// Reset (synchronous) clears counters and loads the registers with 256.
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_stream
// Raster height samples in, grid vertices with position, texture coordinates
// and a unit central-difference normal out, one row behind the input.
// ----------------------------------------------------------------------------
module heightmap_vertex_normal_stream #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  hvns_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output hvns_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [hvns_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [15:0]                           csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int EW = (WW > 11) ? WW : 11;

   logic [10:0]   grid_width_ff;
   logic [15:0]   grid_height_ff, vert_scale_ff, spacing_x_ff, spacing_z_ff;
   logic          csr_hit, cfg_clear;
   logic [EW-1:0] gw_ext;
   logic [WW-1:0] eff_w;
   logic [15:0]   eff_h;

   hvns_pkg::cmd_type cmd;
   logic [AW-1:0]     rd_addr, vcol;

   assign csr_ready = 1'b1;

   // register decode; any listed register restarts the stream
   always_comb begin
      case (csr_index)
         hvns_pkg::CSR_GRID_WIDTH,
         hvns_pkg::CSR_GRID_HEIGHT,
         hvns_pkg::CSR_VERT_SCALE,
         hvns_pkg::CSR_SPACING_X,
         hvns_pkg::CSR_SPACING_Z: csr_hit = 1'b1;
         default:                 csr_hit = 1'b0;
      endcase
   end

   assign cfg_clear = csr_valid & csr_ready & csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 11'(hvns_pkg::CSR_RESET_VALUE);
         grid_height_ff <= hvns_pkg::CSR_RESET_VALUE;
         vert_scale_ff  <= hvns_pkg::CSR_RESET_VALUE;
         spacing_x_ff   <= hvns_pkg::CSR_RESET_VALUE;
         spacing_z_ff   <= hvns_pkg::CSR_RESET_VALUE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hvns_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_data[10:0];
            hvns_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_data;
            hvns_pkg::CSR_VERT_SCALE:  vert_scale_ff  <= csr_data;
            hvns_pkg::CSR_SPACING_X:   spacing_x_ff   <= csr_data;
            hvns_pkg::CSR_SPACING_Z:   spacing_z_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // effective grid size: width clamped to the store depth, zero width and height as one
   assign gw_ext = EW'(grid_width_ff);

   always_comb begin
      if (gw_ext == '0) begin
         eff_w = WW'(1);
      end else if (gw_ext > EW'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(gw_ext);
      end
   end

   assign eff_h = (grid_height_ff == 16'd0) ? 16'd1 : grid_height_ff;

   hvns_ctrl #(
      .AW (AW),
      .WW (WW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cfg_clear (cfg_clear),
      .eff_w     (eff_w),
      .eff_h     (eff_h),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .vcol      (vcol)
   );

   hvns_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW),
      .WW        (WW)
   ) u_dp (
      .clock      (clock),
      .req_data   (req_data),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .vcol       (vcol),
      .eff_w      (eff_w),
      .eff_h      (eff_h),
      .vert_scale (vert_scale_ff),
      .spacing_x  (spacing_x_ff),
      .spacing_z  (spacing_z_ff),
      .rsp_data   (rsp_data)
   );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightmap vertex normal stream testbench
// Drives raster height grids of many sizes and scales through the block. A
// scoreboard mirrors the line stores and counters, works out each vertex and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;
   localparam logic [hvns_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam int WIDTH_MAX   = 1024;
   localparam int SETTLE      = 150;   // a little over the block latency
   localparam int STALL_LIMIT = 4000;
   localparam int ITEM_TARGET = 450;

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of the block state and the queue of vertices due
   // -------------------------------------------------------------------------
   class vertex_scoreboard;
      logic [31:0] prev_row[WIDTH_MAX];
      logic [31:0] older_row[WIDTH_MAX];
      int unsigned col_cnt, row_cnt, drain_cnt;
      int unsigned width_reg, height_reg, hscale, step_x, step_z;
      hvns_pkg::rsp_type vertex_q[$];
      int          errors, checked;

      function void clear();
         col_cnt = 0; row_cnt = 0; drain_cnt = 0;
         width_reg = 256; height_reg = 256; hscale = 256; step_x = 256; step_z = 256;
         errors = 0; checked = 0;
      endfunction

      function int unsigned eff_w();
         return width_reg < 1 ? 1 : (width_reg > WIDTH_MAX ? WIDTH_MAX : width_reg);
      endfunction

      function int unsigned eff_h();
         return height_reg == 0 ? 1 : height_reg;
      endfunction

      function void note_config(logic [hvns_pkg::CSR_INDEX_BITS-1:0] idx, logic [15:0] val);
         case (idx)
            hvns_pkg::CSR_GRID_WIDTH:  width_reg  = val & 16'h07FF;
            hvns_pkg::CSR_GRID_HEIGHT: height_reg = val;
            hvns_pkg::CSR_VERT_SCALE:  hscale     = val;
            hvns_pkg::CSR_SPACING_X:   step_x     = val;
            hvns_pkg::CSR_SPACING_Z:   step_z     = val;
            default: return;
         endcase
         col_cnt = 0; row_cnt = 0; drain_cnt = 0;
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] v);
         logic [63:0] res, bitv;
         res = 0; bitv = hvns_pkg::ROOT_FIRST_BIT;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else res = res >> 1;
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      // rounded unit component, sign applied after the division
      function logic [15:0] unit_comp(logic [63:0] v, logic [63:0] len, logic neg);
         logic [63:0] q;
         q = (v * 16384 + len / 2) / len;
         if (q > 16384) q = 16384;
         return neg ? 16'(-q) : 16'(q);
      endfunction

      function void queue_vertex(int unsigned col, int unsigned row, logic [31:0] c,
                                 logic [31:0] l, logic [31:0] r, logic [31:0] dn,
                                 logic [31:0] up, logic last);
         hvns_pkg::rsp_type v;
         logic        nxneg, nzneg;
         logic [63:0] ax, az, m, a, b, cz, len;
         int          s;
         nxneg = r > l;
         nzneg = up > dn;
         ax = nxneg ? 64'(r) - l : 64'(l) - r;
         az = nzneg ? 64'(up) - dn : 64'(dn) - up;
         m = 512;
         if (ax > m) m = ax;
         if (az > m) m = az;
         s = 0;
         while ((m >> s) >= (64'd1 << 31)) s++;
         a = ax >> s; b = 64'd512 >> s; cz = az >> s;
         len = int_sqrt(a * a + b * b + cz * cz);
         if (len == 0) len = 1;
         v.column      = col[9:0];
         v.grid_row    = row[15:0];
         v.pos_x       = 26'(64'(col) * step_x);
         v.pos_y       = c;
         v.pos_z       = 32'(64'(row) * step_z);
         v.tex_u       = 16'((64'(col) << 16) / eff_w());
         v.tex_v       = 16'((64'(row) << 16) / eff_h());
         v.normal_x    = unit_comp(a, len, nxneg);
         v.normal_y    = 15'(unit_comp(b, len, 1'b0));
         v.normal_z    = unit_comp(cz, len, nzneg);
         v.last_vertex = last;
         vertex_q.push_back(v);
      endfunction

      // returns 1 when the item does something, 0 when the block ignores it
      function bit note_request(hvns_pkg::req_type rq);
         int unsigned w, h, x, z, d;
         logic [31:0] cur, c, l, r, dn;
         w = eff_w(); h = eff_h();
         if (rq.operation == OP_PUSH) begin
            x = col_cnt; z = row_cnt;
            if (z >= h || x >= w) return 0;
            cur = 32'(rq.sample_height * hscale);
            if (z >= 1) begin
               c  = prev_row[x];
               l  = x > 0 ? older_row[x-1] : c;
               r  = x + 1 < w ? prev_row[x+1] : c;
               dn = z >= 2 ? older_row[x] : c;
               queue_vertex(x, z - 1, c, l, r, dn, cur, 1'b0);
            end
            older_row[x] = prev_row[x];
            prev_row[x]  = cur;
            if (x + 1 >= w) begin
               col_cnt = 0; row_cnt = z + 1;
            end else col_cnt = x + 1;
            return 1;
         end
         d = drain_cnt;
         if (row_cnt < h || d >= w) return 0;
         c  = prev_row[d];
         l  = d > 0 ? prev_row[d-1] : c;
         r  = d + 1 < w ? prev_row[d+1] : c;
         dn = h >= 2 ? older_row[d] : c;
         queue_vertex(d, h - 1, c, l, r, dn, c, d + 1 >= w);
         if (d + 1 >= w) begin
            col_cnt = 0; row_cnt = 0; drain_cnt = 0;
         end else drain_cnt = d + 1;
         return 1;
      endfunction

      function void cmp(string fname, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, fname,
                     exp_v, act_v);
         end
      endfunction

      function void check_vertex(hvns_pkg::rsp_type act);
         hvns_pkg::rsp_type e;
         if (vertex_q.size() == 0) begin
            errors++;
            $display("%0t: vertex with none expected, expected nothing, actual %p",
                     $realtime, act);
            return;
         end
         e = vertex_q.pop_front();
         checked++;
         cmp("column", e.column, act.column);
         cmp("grid_row", e.grid_row, act.grid_row);
         cmp("pos_x", e.pos_x, act.pos_x);
         cmp("pos_y", e.pos_y, act.pos_y);
         cmp("pos_z", e.pos_z, act.pos_z);
         cmp("tex_u", e.tex_u, act.tex_u);
         cmp("tex_v", e.tex_v, act.tex_v);
         cmp("normal_x", 64'(e.normal_x), 64'(act.normal_x));
         cmp("normal_y", e.normal_y, act.normal_y);
         cmp("normal_z", 64'(e.normal_z), 64'(act.normal_z));
         cmp("last_vertex", e.last_vertex, act.last_vertex);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   hvns_pkg::req_type req_data = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   hvns_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0, csr_ready;
   logic [hvns_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   vertex_scoreboard sb = new();
   int live_items, sent_items, grids_run, settings_run, burst_left;
   int stall_left, idle_cycles;

   always #5 clock = ~clock;

   heightmap_vertex_normal_stream dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // -------------------------------------------------------------------------
   // Receiver: mostly ready, short stalls, now and then a long one
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 199) < 3) stall_left <= $urandom_range(20, 300);
         else if ($urandom_range(0, 99) < 15) stall_left <= $urandom_range(1, 4);
      end
   end

   // result transfers go straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_vertex(rsp_data);
   end

   // watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // valid is only lowered ahead of a gap, so back-to-back items never
   // lower and raise it in the same step
   task automatic send_item(input logic op, input logic [15:0] hgt);
      hvns_pkg::req_type rq;
      int      gap;
      rq.operation = op;
      rq.sample_height = hgt;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      if (sb.note_request(rq)) live_items++;
   endtask

   // sender pause until every vertex due has come out, then settle
   task automatic drain_out();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
      while (sb.vertex_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [hvns_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.note_config(idx, val);
   endtask

   task automatic set_grid(input logic [15:0] w, input logic [15:0] h, input logic [15:0] hs,
                           input logic [15:0] sx, input logic [15:0] sz);
      drain_out();
      write_csr(hvns_pkg::CSR_GRID_WIDTH, w);
      write_csr(hvns_pkg::CSR_GRID_HEIGHT, h);
      write_csr(hvns_pkg::CSR_VERT_SCALE, hs);
      write_csr(hvns_pkg::CSR_SPACING_X, sx);
      write_csr(hvns_pkg::CSR_SPACING_Z, sz);
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   function automatic logic [15:0] pick_height();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return 16'(1000 + $urandom_range(0, 40));   // gentle slopes
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_scale();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return hvns_pkg::CSR_RESET_VALUE;
         default: return 16'($urandom);
      endcase
   endfunction

   // one grid: pushes then drains, with stray items mixed in at noise percent
   task automatic run_grid(input int pushes, input int drains, input int noise);
      for (int i = 0; i < pushes; i++) begin
         if ($urandom_range(0, 99) < noise) send_item(OP_DRAIN, 16'($urandom));
         send_item(OP_PUSH, pick_height());
      end
      if ($urandom_range(0, 99) < noise) send_item(OP_PUSH, pick_height());
      for (int i = 0; i < drains; i++) send_item(OP_DRAIN, 16'($urandom));
      grids_run++;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int w, h, full;
      sb.clear();
      live_items = 0; sent_items = 0; grids_run = 0; settings_run = 0; burst_left = 0;
      stall_left = 0; idle_cycles = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // 3x3 grid with extreme heights, early drain and late push ignored
      set_grid(16'd3, 16'd3, 16'd256, 16'd256, 16'd256);
      send_item(OP_DRAIN, 16'h0000);
      send_item(OP_PUSH, 16'h0000); send_item(OP_PUSH, 16'hFFFF); send_item(OP_PUSH, 16'h0000);
      send_item(OP_PUSH, 16'hFFFF); send_item(OP_PUSH, 16'h0000); send_item(OP_PUSH, 16'hFFFF);
      send_item(OP_PUSH, 16'd100); send_item(OP_PUSH, 16'd200); send_item(OP_PUSH, 16'd300);
      send_item(OP_PUSH, 16'h5555);
      repeat (4) send_item(OP_DRAIN, 16'hAAAA);

      // zero width and height act as one; largest scales
      set_grid(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_PUSH, 16'hFFFF);
      send_item(OP_DRAIN, 16'h0000);

      // single column, tallest grid, left unfinished; unused index ignored
      set_grid(16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0);
      write_csr(CSR_UNUSED, 16'h1234);
      csr_valid <= 1'b0;
      send_item(OP_PUSH, 16'd7); send_item(OP_PUSH, 16'hFFFF); send_item(OP_PUSH, 16'd0);
      drain_out();

      // width clamps to the line store size; a partial first row
      set_grid(16'hFFFF, 16'd1, 16'd0, 16'd1, 16'd1);
      run_grid(48, 2, 0);

      // random grids, small, some broken off early
      while (sent_items < ITEM_TARGET) begin
         w = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : $urandom_range(1, 8);
         h = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : $urandom_range(1, 6);
         set_grid(16'(w), 16'(h), pick_scale(), pick_scale(), pick_scale());
         full = w * h;
         if ($urandom_range(0, 5) == 0)
            run_grid($urandom_range(0, full), $urandom_range(0, 2), 15);
         else begin
            run_grid(full / 2, 0, 10);
            if (grids_run == 8) drain_out();   // sender waits for every vertex once
            run_grid(full - full / 2, w + $urandom_range(0, 1), 10);
         end
      end

      // wind down
      drain_out();
      $display("Ran %0d grids over %0d register settings, %0d items (%0d acted on), %0d vertices checked.",
               grids_run, settings_run, sent_items, live_items, sb.checked);
      $display("Covered clamped sizes, extreme scales and heights, stray and broken items.");
      if (sb.errors == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule
